### rtl/lfps_pkg.sv
`default_nettype none

package lfps_pkg;

    // Field widths
    localparam int PWM_W      = 8;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;
    localparam int COUNT_W    = 5;
    localparam int TICKS_W    = 9;
    localparam int PC_W       = 3;
    localparam int ACC_W      = 20;

    // Steering constants
    localparam logic [COUNT_W-1:0] SIDE_COUNT_MAX = 5'd20;
    localparam logic [TICKS_W-1:0] TICKS_MAX      = 9'd511;
    localparam logic [PWM_W-1:0]   PWM_FULL       = 8'd255;
    localparam logic [PWM_W-1:0]   TURN_FAST      = 8'd255;
    localparam logic [PWM_W-1:0]   TURN_SLOW      = 8'd10;
    localparam logic [PWM_W-1:0]   NUDGE_SLOW     = 8'd20;
    localparam logic [PWM_W-1:0]   SIDE_DROP      = 8'd20;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_Q8      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_Q8   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN_SPEED  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_TIMEOUT   = 4'd7;

    typedef enum logic [MODE_W-1:0] {
        MODE_CENTRE = 2'd0,
        MODE_SIDE   = 2'd1,
        MODE_HARD   = 2'd2
    } mode_t;

    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_RUN  = 1'b1
    } seq_state_t;

    // Multiplier operand A (unsigned gain or weight)
    typedef enum logic [2:0] {
        MA_ALPHA   = 3'd0,
        MA_ALPHA_C = 3'd1,
        MA_GAIN_P  = 3'd2,
        MA_GAIN_D  = 3'd3,
        MA_GAIN_I  = 3'd4
    } mul_a_t;

    // Multiplier operand B (small signed state value)
    typedef enum logic [1:0] {
        MB_DERIV = 2'd0,
        MB_DERR  = 2'd1,
        MB_ERR   = 2'd2,
        MB_INTEG = 2'd3
    } mul_b_t;

    typedef enum logic [1:0] {
        ACC_HOLD     = 2'd0,
        ACC_LOAD     = 2'd1,
        ACC_ADD      = 2'd2,
        ACC_SHL8_ADD = 2'd3
    } acc_op_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_FILTER = 2'd1,
        ACT_DRIVE  = 2'd2,
        ACT_TURN   = 2'd3
    } act_t;

    typedef struct packed {
        mul_a_t            mul_a;
        mul_b_t            mul_b;
        acc_op_t           acc_op;
        act_t              act;
        logic              br_hard;
        logic [PC_W-1:0]   target;
        logic              last;
    } ucode_t;

    localparam logic [PC_W-1:0] PC_TURN = 3'd7;

    // Control store: one word per step
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t uc;
        unique case (pc)
            3'd0: uc = '{MA_ALPHA,   MB_DERIV, ACC_LOAD,     ACT_NONE,   1'b1, PC_TURN, 1'b0};
            3'd1: uc = '{MA_ALPHA_C, MB_DERR,  ACC_ADD,      ACT_NONE,   1'b0, 3'd0,    1'b0};
            3'd2: uc = '{MA_ALPHA,   MB_DERIV, ACC_HOLD,     ACT_FILTER, 1'b0, 3'd0,    1'b0};
            3'd3: uc = '{MA_GAIN_P,  MB_ERR,   ACC_LOAD,     ACT_NONE,   1'b0, 3'd0,    1'b0};
            3'd4: uc = '{MA_GAIN_D,  MB_DERIV, ACC_ADD,      ACT_NONE,   1'b0, 3'd0,    1'b0};
            3'd5: uc = '{MA_GAIN_I,  MB_INTEG, ACC_SHL8_ADD, ACT_NONE,   1'b0, 3'd0,    1'b0};
            3'd6: uc = '{MA_ALPHA,   MB_DERIV, ACC_HOLD,     ACT_DRIVE,  1'b0, 3'd0,    1'b1};
            3'd7: uc = '{MA_ALPHA,   MB_DERIV, ACC_HOLD,     ACT_TURN,   1'b0, 3'd0,    1'b1};
        endcase
        return uc;
    endfunction

endpackage

`default_nettype wire

### rtl/lfps_in_if.sv
`default_nettype none

interface lfps_in_if;
    logic valid;
    logic ready;
    logic left_sensor;
    logic centre_sensor;
    logic right_sensor;

    modport source (output valid, output left_sensor, output centre_sensor,
                    output right_sensor, input ready);
    modport sink (input valid, input left_sensor, input centre_sensor,
                  input right_sensor, output ready);
endinterface

`default_nettype wire

### rtl/lfps_out_if.sv
`default_nettype none

interface lfps_out_if
    import lfps_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [PWM_W-1:0]  pwm_a;
    logic [PWM_W-1:0]  pwm_b;
    logic              pin_a_high;
    logic              pin_b_high;
    logic [MODE_W-1:0] mode;

    modport source (output valid, output pwm_a, output pwm_b, output pin_a_high,
                    output pin_b_high, output mode, input ready);
    modport sink (input valid, input pwm_a, input pwm_b, input pin_a_high,
                  input pin_b_high, input mode, output ready);
endinterface

`default_nettype wire

### rtl/lfps_cfg_if.sv
`default_nettype none

interface lfps_cfg_if
    import lfps_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/line_follower_pid_steering_core.sv
`default_nettype none

// Line-follower PID steering core.
// sensor: one item per control tick carrying the left, centre and right line
//   sensor bits. Accepted when valid and ready are high at a rising edge.
// motor: one item per sensor item: pwm_a, pwm_b, the two side pins and the
//   mode (centre, side only, hard turn).
// cfg: register writes (index, data), always ready; write only while idle.
// Steps: centre/side ticks run the first 7 steps of the control store; a hard-turn
//   tick branches from the first step to the turn step (2 steps). The output
//   register loads at the edge that ends the last step. The sequencer then
//   returns to idle, where it can accept the next item; the step count of the
//   control store driving the single shared multiplier sets the time per item.
// Throughput: one item in flight; sensor.ready is high while the sequencer
//   is idle, so a new item may enter while the previous result still waits.
// Stall: if the motor side holds ready low, the last step holds until the
//   output register frees up; no state commits before then.
// Reset: registers take their default gains, the tick mode starts at hard turn, motors
//   and all run state clear. The first centre or side tick after reset
//   therefore wraps around and starts from a clean state.
module line_follower_pid_steering_core
    import lfps_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    lfps_cfg_if.sink   cfg,
    lfps_in_if.sink    sensor,
    lfps_out_if.source motor
);

    // Configuration registers
    logic [7:0]  gain_p_reg, gain_p_next;
    logic [7:0]  gain_d_reg, gain_d_next;
    logic [9:0]  gain_i_reg, gain_i_next;
    logic [8:0]  smooth_reg, smooth_next;
    logic [3:0]  int_lim_reg, int_lim_next;
    logic [7:0]  base_reg, base_next;
    logic [7:0]  floor_reg, floor_next;
    logic [7:0]  timeout_reg, timeout_next;

    // Sequencer
    seq_state_t       state_reg, state_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    ucode_t           ucw;
    logic             accept;
    logic             running;
    logic             advance;

    // Tick inputs and run state
    logic                    left_reg, left_next;
    logic                    right_reg, right_next;
    mode_t                   phase_reg, phase_next;
    logic [COUNT_W-1:0]      lcount_reg, lcount_next;
    logic [COUNT_W-1:0]      rcount_reg, rcount_next;
    logic signed [1:0]       last_side_reg, last_side_next;
    logic signed [1:0]       prev_err_reg, prev_err_next;
    logic signed [2:0]       deriv_reg, deriv_next;
    logic signed [4:0]       integ_reg, integ_next;
    logic [TICKS_W-1:0]      ticks_reg, ticks_next;
    logic [PWM_W-1:0]        mpwm_a_reg, mpwm_a_next;
    logic [PWM_W-1:0]        mpwm_b_reg, mpwm_b_next;
    logic                    mpin_a_reg, mpin_a_next;
    logic                    mpin_b_reg, mpin_b_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    // Output register
    logic             ovalid_reg, ovalid_next;
    logic [PWM_W-1:0] opwm_a_reg, opwm_a_next;
    logic [PWM_W-1:0] opwm_b_reg, opwm_b_next;
    logic             opin_a_reg, opin_a_next;
    logic             opin_b_reg, opin_b_next;
    mode_t            omode_reg, omode_next;

    // Datapath
    mode_t                   in_mode;
    logic [8:0]              alpha;
    logic [8:0]              alpha_c;
    logic signed [1:0]       err;
    logic signed [2:0]       derr;
    logic [10:0]             mul_a_val;
    logic signed [4:0]       mul_b_val;
    logic signed [16:0]      prod;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-9:0] acc_q;
    logic signed [ACC_W-9:0] acc_trunc;
    logic signed [5:0]       integ_sum;
    logic signed [5:0]       lim_s;
    logic signed [11:0]      sum_a;
    logic signed [11:0]      sum_b;
    logic [TICKS_W-1:0]      ticks_inc;
    logic                    side_mode;

    // Clamp a corrected speed into the PWM range of the current mode
    function automatic logic [PWM_W-1:0] drive_level(input logic signed [11:0] v,
                                                     input logic [PWM_W-1:0] fl,
                                                     input logic side);
        logic [PWM_W-1:0] lvl;
        if (v > 12'sd255) begin
            lvl = PWM_FULL;
        end else if (v < $signed({4'b0000, fl})) begin
            if (!side) begin
                lvl = fl;
            end else if (fl >= SIDE_DROP) begin
                lvl = fl - SIDE_DROP;
            end else begin
                lvl = '0;
            end
        end else begin
            lvl = v[PWM_W-1:0];
        end
        return lvl;
    endfunction

    assign ucw = ucode_rom(pc_reg);

    // ------------------------------------------------------------------
    // Sequencer control: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (accept) begin
                    state_next = SEQ_RUN;
                    pc_next    = '0;
                end
            end
            SEQ_RUN:
            begin
                if (advance) begin
                    if (ucw.last) begin
                        state_next = SEQ_IDLE;
                    end else if (ucw.br_hard && phase_reg == MODE_HARD) begin
                        pc_next = ucw.target;
                    end else begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
            end
        endcase
    end

    // Sequencer control: outputs
    always_comb begin
        sensor.ready = (state_reg == SEQ_IDLE);
        running      = (state_reg == SEQ_RUN);
    end

    assign accept  = sensor.valid && sensor.ready;
    // Hold the last step while the previous result still waits
    assign advance = running && !(ucw.last && ovalid_reg && !motor.ready);
    assign cfg.ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_comb begin
        gain_p_next  = gain_p_reg;
        gain_d_next  = gain_d_reg;
        gain_i_next  = gain_i_reg;
        smooth_next  = smooth_reg;
        int_lim_next = int_lim_reg;
        base_next    = base_reg;
        floor_next   = floor_reg;
        timeout_next = timeout_reg;
        if (cfg.valid && cfg.ready) begin
            unique case (cfg.index)
                REG_GAIN_P:         gain_p_next  = cfg.data[7:0];
                REG_GAIN_D:         gain_d_next  = cfg.data[7:0];
                REG_GAIN_I_Q8:      gain_i_next  = cfg.data[9:0];
                REG_SMOOTHING_Q8:   smooth_next  = cfg.data[8:0];
                REG_INTEGRAL_LIMIT: int_lim_next = cfg.data[3:0];
                REG_BASE_SPEED:     base_next    = cfg.data[7:0];
                REG_MIN_RUN_SPEED:  floor_next   = cfg.data[7:0];
                REG_TURN_TIMEOUT:   timeout_next = cfg.data[7:0];
                default:            ; // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier and operand selection
    // ------------------------------------------------------------------
    always_comb begin
        // Filter weight saturates at 1.0 in Q8
        alpha   = smooth_reg[8] ? 9'd256 : smooth_reg;
        alpha_c = 9'd256 - alpha;
        err     = $signed({1'b0, right_reg}) - $signed({1'b0, left_reg});
        derr    = {err[1], err} - {prev_err_reg[1], prev_err_reg};

        unique case (ucw.mul_a)
            MA_ALPHA:   mul_a_val = {2'b00, alpha};
            MA_ALPHA_C: mul_a_val = {2'b00, alpha_c};
            MA_GAIN_P:  mul_a_val = {3'b000, gain_p_reg};
            MA_GAIN_D:  mul_a_val = {3'b000, gain_d_reg};
            MA_GAIN_I:  mul_a_val = {1'b0, gain_i_reg};
            default:    mul_a_val = '0;
        endcase

        unique case (ucw.mul_b)
            MB_DERIV: mul_b_val = {{2{deriv_reg[2]}}, deriv_reg};
            MB_DERR:  mul_b_val = {{2{derr[2]}}, derr};
            MB_ERR:   mul_b_val = {{3{err[1]}}, err};
            MB_INTEG: mul_b_val = integ_reg;
        endcase

        prod     = $signed({1'b0, mul_a_val}) * mul_b_val;
        prod_ext = {{(ACC_W-17){prod[16]}}, prod};

        // Divide the accumulator by 256, rounding toward zero
        acc_q     = acc_reg[ACC_W-1:8];
        acc_trunc = acc_q + ((acc_reg[ACC_W-1] && acc_reg[7:0] != 8'd0) ? 12'sd1 : 12'sd0);
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        left_next      = left_reg;
        right_next     = right_reg;
        phase_next     = phase_reg;
        lcount_next    = lcount_reg;
        rcount_next    = rcount_reg;
        last_side_next = last_side_reg;
        prev_err_next  = prev_err_reg;
        deriv_next     = deriv_reg;
        integ_next     = integ_reg;
        ticks_next     = ticks_reg;
        mpwm_a_next    = mpwm_a_reg;
        mpwm_b_next    = mpwm_b_reg;
        mpin_a_next    = mpin_a_reg;
        mpin_b_next    = mpin_b_reg;
        acc_next       = acc_reg;
        ovalid_next    = ovalid_reg;
        opwm_a_next    = opwm_a_reg;
        opwm_b_next    = opwm_b_reg;
        opin_a_next    = opin_a_reg;
        opin_b_next    = opin_b_reg;
        omode_next     = omode_reg;

        in_mode   = sensor.centre_sensor ? MODE_CENTRE
                  : ((sensor.left_sensor || sensor.right_sensor) ? MODE_SIDE : MODE_HARD);
        integ_sum = {integ_reg[4], integ_reg} + {{4{err[1]}}, err};
        lim_s     = $signed({2'b00, int_lim_reg});
        sum_a     = $signed({4'b0000, base_reg}) + acc_trunc;
        sum_b     = $signed({4'b0000, base_reg}) - acc_trunc;
        ticks_inc = (ticks_reg < TICKS_MAX) ? ticks_reg + 1'b1 : ticks_reg;
        side_mode = (phase_reg == MODE_SIDE);

        if (motor.ready) begin
            ovalid_next = 1'b0;
        end

        // Latch the tick; a mode that wraps back around stops the motors
        if (accept) begin
            left_next  = sensor.left_sensor;
            right_next = sensor.right_sensor;
            phase_next = in_mode;
            if (in_mode < phase_reg) begin
                lcount_next    = '0;
                rcount_next    = '0;
                last_side_next = '0;
                deriv_next     = '0;
                integ_next     = '0;
                ticks_next     = '0;
                mpwm_a_next    = '0;
                mpwm_b_next    = '0;
                mpin_a_next    = 1'b0;
                mpin_b_next    = 1'b0;
            end
        end

        if (advance) begin
            unique case (ucw.acc_op)
                ACC_HOLD:     acc_next = acc_reg;
                ACC_LOAD:     acc_next = prod_ext;
                ACC_ADD:      acc_next = acc_reg + prod_ext;
                ACC_SHL8_ADD: acc_next = (acc_reg <<< 8) + prod_ext;
            endcase

            unique case (ucw.act)
                ACT_NONE:
                begin
                end
                ACT_FILTER:
                begin
                    // Filtered derivative, clamped integral, remember error
                    deriv_next    = acc_trunc[2:0];
                    prev_err_next = err;
                    if (integ_sum > lim_s) begin
                        integ_next = lim_s[4:0];
                    end else if (integ_sum < -lim_s) begin
                        integ_next = 5'(-lim_s);
                    end else begin
                        integ_next = integ_sum[4:0];
                    end
                end
                ACT_DRIVE:
                begin
                    if (!side_mode) begin
                        mpwm_a_next = PWM_FULL;
                        mpwm_b_next = PWM_FULL;
                    end
                    if (left_reg || right_reg) begin
                        mpwm_a_next = drive_level(sum_a, floor_reg, side_mode);
                        mpwm_b_next = drive_level(sum_b, floor_reg, side_mode);
                        mpin_a_next = left_reg;
                        mpin_b_next = !left_reg;
                    end
                    if (right_reg && !left_reg && rcount_reg < SIDE_COUNT_MAX) begin
                        rcount_next = rcount_reg + 1'b1;
                    end
                    if (left_reg && !right_reg && lcount_reg < SIDE_COUNT_MAX) begin
                        lcount_next = lcount_reg + 1'b1;
                    end
                    last_side_next = right_reg ? 2'sd1 : (left_reg ? -2'sd1 : 2'sd0);
                end
                ACT_TURN:
                begin
                    ticks_next = ticks_inc;
                    if (lcount_reg > rcount_reg) begin
                        mpwm_a_next = TURN_FAST;
                        mpwm_b_next = TURN_SLOW;
                    end else if (rcount_reg > lcount_reg) begin
                        mpwm_a_next = TURN_SLOW;
                        mpwm_b_next = TURN_FAST;
                    end else if (last_side_reg == -2'sd1) begin
                        mpwm_a_next = TURN_FAST;
                        mpwm_b_next = NUDGE_SLOW;
                    end else if (last_side_reg == 2'sd1) begin
                        mpwm_a_next = NUDGE_SLOW;
                        mpwm_b_next = TURN_FAST;
                    end
                    // Timeout: stop the motors and forget the lean
                    if (ticks_inc > {1'b0, timeout_reg}) begin
                        mpwm_a_next    = '0;
                        mpwm_b_next    = '0;
                        mpin_a_next    = 1'b0;
                        mpin_b_next    = 1'b0;
                        lcount_next    = '0;
                        rcount_next    = '0;
                        last_side_next = '0;
                    end
                end
            endcase

            // Publish the motor levels on the last step
            if (ucw.last) begin
                ovalid_next = 1'b1;
                opwm_a_next = mpwm_a_next;
                opwm_b_next = mpwm_b_next;
                opin_a_next = mpin_a_next;
                opin_b_next = mpin_b_next;
                omode_next  = phase_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            gain_p_reg    <= 8'd70;
            gain_d_reg    <= 8'd40;
            gain_i_reg    <= 10'd333;
            smooth_reg    <= 9'd141;
            int_lim_reg   <= 4'd8;
            base_reg      <= 8'd220;
            floor_reg     <= 8'd50;
            timeout_reg   <= 8'd48;
            state_reg     <= SEQ_IDLE;
            pc_reg        <= '0;
            phase_reg     <= MODE_HARD;
            lcount_reg    <= '0;
            rcount_reg    <= '0;
            last_side_reg <= '0;
            prev_err_reg  <= '0;
            deriv_reg     <= '0;
            integ_reg     <= '0;
            ticks_reg     <= '0;
            mpwm_a_reg    <= '0;
            mpwm_b_reg    <= '0;
            mpin_a_reg    <= 1'b0;
            mpin_b_reg    <= 1'b0;
            ovalid_reg    <= 1'b0;
        end else begin
            gain_p_reg    <= gain_p_next;
            gain_d_reg    <= gain_d_next;
            gain_i_reg    <= gain_i_next;
            smooth_reg    <= smooth_next;
            int_lim_reg   <= int_lim_next;
            base_reg      <= base_next;
            floor_reg     <= floor_next;
            timeout_reg   <= timeout_next;
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            phase_reg     <= phase_next;
            lcount_reg    <= lcount_next;
            rcount_reg    <= rcount_next;
            last_side_reg <= last_side_next;
            prev_err_reg  <= prev_err_next;
            deriv_reg     <= deriv_next;
            integ_reg     <= integ_next;
            ticks_reg     <= ticks_next;
            mpwm_a_reg    <= mpwm_a_next;
            mpwm_b_reg    <= mpwm_b_next;
            mpin_a_reg    <= mpin_a_next;
            mpin_b_reg    <= mpin_b_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk) begin
        left_reg   <= left_next;
        right_reg  <= right_next;
        acc_reg    <= acc_next;
        opwm_a_reg <= opwm_a_next;
        opwm_b_reg <= opwm_b_next;
        opin_a_reg <= opin_a_next;
        opin_b_reg <= opin_b_next;
        omode_reg  <= omode_next;
    end

    assign motor.valid      = ovalid_reg;
    assign motor.pwm_a      = opwm_a_reg;
    assign motor.pwm_b      = opwm_b_reg;
    assign motor.pin_a_high = opin_a_reg;
    assign motor.pin_b_high = opin_b_reg;
    assign motor.mode       = omode_reg;

endmodule

`default_nettype wire

### test/line_follower_pid_steering_core_tb.sv
module line_follower_pid_steering_core_tb
    import lfps_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Steering constants, kept apart from the block's own copies
    localparam int PWM_MAX     = 255;
    localparam int FAST_PWM    = 255;
    localparam int SLOW_PWM    = 10;
    localparam int NUDGE_PWM   = 20;
    localparam int FLOOR_DROP  = 20;
    localparam int SIDE_LIMIT  = 20;
    localparam int TICK_CEIL   = 511;

    // Run shape
    localparam int SETTING_RUNS  = 7;
    localparam int PHASE_ITEMS   = 170;
    localparam int LOST_BURST    = 520;
    localparam int IDLE_MAX      = 10;
    localparam int REPORT_MAX    = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [PWM_W-1:0] pwm_a;
        logic [PWM_W-1:0] pwm_b;
        logic             pin_a;
        logic             pin_b;
        mode_t            mode;
    } motor_cmd_t;

    typedef struct {
        int gain_p;
        int gain_d;
        int gain_i;
        int smooth;
        int ilim;
        int base;
        int floor_speed;
        int timeout;
    } steer_cfg_t;

    // One row of the directed sweep: sensor bits, and a hand-written command
    // where it is obvious (otherwise the predictor supplies it)
    typedef struct packed {
        logic       left_on;
        logic       centre_on;
        logic       right_on;
        logic       typed;
        motor_cmd_t cmd;
    } probe_row_t;

    localparam motor_cmd_t NO_CMD = '0;
    localparam int PROBE_ROWS = 24;
    localparam probe_row_t PROBE_TABLE [PROBE_ROWS] = '{
        // lost right after reset: motors still off, hard turn
        '{1'b0, 1'b0, 1'b0, 1'b1, '{8'd0, 8'd0, 1'b0, 1'b0, MODE_HARD}},
        // centre only: wraps around, full speed, pins cleared
        '{1'b0, 1'b1, 1'b0, 1'b1, '{8'd255, 8'd255, 1'b0, 1'b0, MODE_CENTRE}},
        '{1'b0, 1'b1, 1'b1, 1'b0, NO_CMD},
        '{1'b1, 1'b1, 1'b0, 1'b0, NO_CMD},
        // counts tied, last lean left: nudge left
        '{1'b0, 1'b0, 1'b0, 1'b1, '{8'd255, 8'd20, 1'b1, 1'b0, MODE_HARD}},
        '{1'b1, 1'b1, 1'b1, 1'b0, NO_CMD},
        // counts clear, last lean right: nudge right
        '{1'b0, 1'b0, 1'b0, 1'b1, '{8'd20, 8'd255, 1'b1, 1'b0, MODE_HARD}},
        '{1'b1, 1'b0, 1'b0, 1'b0, NO_CMD},
        '{1'b1, 1'b0, 1'b0, 1'b0, NO_CMD},
        '{1'b0, 1'b0, 1'b1, 1'b0, NO_CMD},
        '{1'b1, 1'b0, 1'b1, 1'b0, NO_CMD},
        '{1'b0, 1'b0, 1'b0, 1'b0, NO_CMD},
        '{1'b0, 1'b0, 1'b0, 1'b0, NO_CMD},
        '{1'b0, 1'b0, 1'b1, 1'b0, NO_CMD},
        '{1'b0, 1'b0, 1'b1, 1'b0, NO_CMD},
        '{1'b0, 1'b0, 1'b0, 1'b0, NO_CMD},
        '{1'b0, 1'b1, 1'b0, 1'b1, '{8'd255, 8'd255, 1'b0, 1'b0, MODE_CENTRE}},
        '{1'b0, 1'b1, 1'b0, 1'b1, '{8'd255, 8'd255, 1'b0, 1'b0, MODE_CENTRE}},
        '{1'b1, 1'b1, 1'b0, 1'b0, NO_CMD},
        '{1'b1, 1'b1, 1'b0, 1'b0, NO_CMD},
        '{1'b0, 1'b1, 1'b0, 1'b0, NO_CMD},
        '{1'b0, 1'b1, 1'b1, 1'b0, NO_CMD},
        '{1'b0, 1'b0, 1'b1, 1'b0, NO_CMD},
        '{1'b0, 1'b0, 1'b0, 1'b0, NO_CMD}
    };

    logic clk = 1'b0;
    logic rst_n;

    lfps_cfg_if cfg_bus ();
    lfps_in_if  sensor_bus ();
    lfps_out_if motor_bus ();

    line_follower_pid_steering_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .sensor (sensor_bus),
        .motor  (motor_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predicted steering state and register copy
    steer_cfg_t steer_set;
    mode_t      run_phase;
    int         left_cnt;
    int         right_cnt;
    int         last_dir;
    int         prev_err;
    int         deriv;
    int         integ;
    int         hard_cnt;
    logic [PWM_W-1:0] pwm_a_q;
    logic [PWM_W-1:0] pwm_b_q;
    logic             pin_a_q;
    logic             pin_b_q;

    motor_cmd_t pending_cmds [$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         course_items;
    bit         no_idle = 1'b0;

    // Drop the per-run memory: side counts, lean, filter, integral, lost ticks
    function automatic void drop_run_state();
        left_cnt  = 0;
        right_cnt = 0;
        last_dir  = 0;
        deriv     = 0;
        integ     = 0;
        hard_cnt  = 0;
    endfunction

    function automatic void steer_reset();
        steer_set = '{70, 40, 333, 141, 8, 220, 50, 48};
        run_phase = MODE_HARD;
        drop_run_state();
        prev_err = 0;
        pwm_a_q  = '0;
        pwm_b_q  = '0;
        pin_a_q  = 1'b0;
        pin_b_q  = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_GAIN_P:         steer_set.gain_p      = int'(data[7:0]);
            REG_GAIN_D:         steer_set.gain_d      = int'(data[7:0]);
            REG_GAIN_I_Q8:      steer_set.gain_i      = int'(data[9:0]);
            REG_SMOOTHING_Q8:   steer_set.smooth      = int'(data[8:0]);
            REG_INTEGRAL_LIMIT: steer_set.ilim        = int'(data[3:0]);
            REG_BASE_SPEED:     steer_set.base        = int'(data[7:0]);
            REG_MIN_RUN_SPEED:  steer_set.floor_speed = int'(data[7:0]);
            REG_TURN_TIMEOUT:   steer_set.timeout     = int'(data[7:0]);
            default: ;
        endcase
    endfunction

    // Clamp a motor sum: centre mode floors at the run speed, side mode
    // drops below it by a fixed margin (never under zero)
    function automatic logic [PWM_W-1:0] drive_level(input int v, input bit side);
        int floor_v;
        floor_v = steer_set.floor_speed;
        if (v > PWM_MAX)
            return PWM_W'(PWM_MAX);
        if (v < floor_v)
        begin
            if (!side)
                return PWM_W'(floor_v);
            return (floor_v >= FLOOR_DROP) ? PWM_W'(floor_v - FLOOR_DROP) : '0;
        end
        return PWM_W'(v);
    endfunction

    // Advance the predicted state by one sensor tick and return the command
    function automatic motor_cmd_t steer_tick(input logic l, input logic c, input logic r);
        mode_t      m;
        bit         side;
        int         e;
        int         a;
        int         total;
        int         corr;
        motor_cmd_t cmd;
        m = c ? MODE_CENTRE : ((l | r) ? MODE_SIDE : MODE_HARD);
        // a lower mode than the current one wraps around: stop and start clean
        if (m < run_phase)
        begin
            drop_run_state();
            pwm_a_q = '0;
            pwm_b_q = '0;
            pin_a_q = 1'b0;
            pin_b_q = 1'b0;
        end
        run_phase = m;
        if (m != MODE_HARD)
        begin
            side = (m == MODE_SIDE);
            e = (r ? 1 : 0) - (l ? 1 : 0);
            a = (steer_set.smooth > 256) ? 256 : steer_set.smooth;
            // signed int division truncates toward zero
            deriv = (a * deriv + (256 - a) * (e - prev_err)) / 256;
            integ = integ + e;
            if (integ > steer_set.ilim)
                integ = steer_set.ilim;
            else if (integ < -steer_set.ilim)
                integ = -steer_set.ilim;
            prev_err = e;
            total = 256 * (steer_set.gain_p * e + steer_set.gain_d * deriv)
                    + steer_set.gain_i * integ;
            corr = total / 256;
            if (!side)
            begin
                pwm_a_q = PWM_W'(PWM_MAX);
                pwm_b_q = PWM_W'(PWM_MAX);
            end
            if (l || r)
            begin
                pwm_a_q = drive_level(steer_set.base + corr, side);
                pwm_b_q = drive_level(steer_set.base - corr, side);
                pin_a_q = l;
                pin_b_q = !l;
            end
            if (r && !l && right_cnt < SIDE_LIMIT)
                right_cnt++;
            if (l && !r && left_cnt < SIDE_LIMIT)
                left_cnt++;
            last_dir = r ? 1 : (l ? -1 : 0);
        end
        else
        begin
            if (hard_cnt < TICK_CEIL)
                hard_cnt++;
            if (left_cnt > right_cnt)
            begin
                pwm_a_q = PWM_W'(FAST_PWM);
                pwm_b_q = PWM_W'(SLOW_PWM);
            end
            else if (right_cnt > left_cnt)
            begin
                pwm_a_q = PWM_W'(SLOW_PWM);
                pwm_b_q = PWM_W'(FAST_PWM);
            end
            else if (last_dir == -1)
            begin
                pwm_a_q = PWM_W'(FAST_PWM);
                pwm_b_q = PWM_W'(NUDGE_PWM);
            end
            else if (last_dir == 1)
            begin
                pwm_a_q = PWM_W'(NUDGE_PWM);
                pwm_b_q = PWM_W'(FAST_PWM);
            end
            // lost for too long: stop the motors and forget the lean
            if (hard_cnt > steer_set.timeout)
            begin
                pwm_a_q   = '0;
                pwm_b_q   = '0;
                pin_a_q   = 1'b0;
                pin_b_q   = 1'b0;
                left_cnt  = 0;
                right_cnt = 0;
                last_dir  = 0;
            end
        end
        cmd = '{pwm_a_q, pwm_b_q, pin_a_q, pin_b_q, m};
        return cmd;
    endfunction

    // Wait draw for either side; zero during a no-idle stretch
    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    function automatic void note_error(input string what, input int want, input int got);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Present one sensor item, hold it until accepted, then log the command
    // it must produce. Called at a rising edge; leaves valid high so that a
    // zero gap keeps the next item back to back.
    task automatic send_item(input logic l, input logic c, input logic r,
                             input logic typed, input motor_cmd_t typed_cmd);
        int         gap;
        motor_cmd_t predicted;
        gap = idle_draw();
        if (gap > 0)
        begin
            sensor_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sensor_bus.valid         <= 1'b1;
        sensor_bus.left_sensor   <= l;
        sensor_bus.centre_sensor <= c;
        sensor_bus.right_sensor  <= r;
        do @(posedge clk); while (!sensor_bus.ready);
        predicted = steer_tick(l, c, r);
        pending_cmds.push_back(typed ? typed_cmd : predicted);
    endtask

    task automatic send_sensors(input logic l, input logic c, input logic r);
        send_item(l, c, r, 1'b0, NO_CMD);
        course_items++;
    endtask

    // Hold off new items until every logged command has come back
    task automatic wait_drained();
        sensor_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_cmds.size() != 0)
            @(posedge clk);
    endtask

    // Write one register; the caller drops valid after the last write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge clk); while (!cfg_bus.ready);
        apply_reg(idx, data);
    endtask

    // Write every register, plus one index past the map that must be ignored
    task automatic load_settings(input int gp, input int gd, input int gi, input int sm,
                                 input int il, input int bs, input int fl, input int to);
        cfg_write(REG_GAIN_P, CFG_DATA_W'(gp));
        cfg_write(REG_GAIN_D, CFG_DATA_W'(gd));
        cfg_write(REG_GAIN_I_Q8, CFG_DATA_W'(gi));
        cfg_write(REG_SMOOTHING_Q8, CFG_DATA_W'(sm));
        cfg_write(REG_INTEGRAL_LIMIT, CFG_DATA_W'(il));
        cfg_write(REG_BASE_SPEED, CFG_DATA_W'(bs));
        cfg_write(REG_MIN_RUN_SPEED, CFG_DATA_W'(fl));
        cfg_write(REG_TURN_TIMEOUT, CFG_DATA_W'(to));
        cfg_write(CFG_IDX_W'($urandom_range(int'(REG_TURN_TIMEOUT) + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
        cfg_bus.valid <= 1'b0;
    endtask

    // One trip off the line: ride the centre, drift to a side (long enough
    // to saturate the lean counters now and then), lose the line for a
    // while (sometimes past the timeout), and come back on the next trip
    task automatic run_excursion();
        int   n;
        int   dir;
        logic sl;
        logic sr;
        n = $urandom_range(1, 8);
        repeat (n)
            send_sensors($urandom_range(0, 3) == 0, 1'b1, $urandom_range(0, 3) == 0);
        dir = $urandom_range(0, 4);
        sl = (dir <= 1) || (dir == 4);
        sr = (dir >= 2);
        n = $urandom_range(1, 25);
        repeat (n)
            send_sensors(sl, 1'b0, sr);
        if ($urandom_range(0, 3) == 0)
            n = (steer_set.timeout < 68) ? steer_set.timeout + $urandom_range(1, 3)
                                         : $urandom_range(0, 70);
        else
            n = $urandom_range(0, 6);
        repeat (n)
            send_sensors(1'b0, 1'b0, 1'b0);
    endtask

    // Mostly well-formed excursions, the rest raw sensor noise
    task automatic drive_course(input int budget);
        int n;
        course_items = 0;
        while (course_items < budget)
        begin
            no_idle = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) < 7)
                run_excursion();
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_sensors(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
            end
        end
        no_idle = 1'b0;
    endtask

    // Motor side: stall at random, check each accepted item against the
    // oldest logged command
    initial
    begin
        int         stall;
        motor_cmd_t want;
        motor_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_draw();
            if (stall > 0)
            begin
                motor_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            motor_bus.ready <= 1'b1;
            do @(posedge clk); while (motor_bus.valid !== 1'b1);
            if (pending_cmds.size() == 0)
                note_error("unexpected motor item, mode", -1, int'(motor_bus.mode));
            else
            begin
                want = pending_cmds.pop_front();
                if (motor_bus.pwm_a !== want.pwm_a)
                    note_error("pwm_a", int'(want.pwm_a), int'(motor_bus.pwm_a));
                if (motor_bus.pwm_b !== want.pwm_b)
                    note_error("pwm_b", int'(want.pwm_b), int'(motor_bus.pwm_b));
                if (motor_bus.pin_a_high !== want.pin_a)
                    note_error("pin_a_high", int'(want.pin_a), int'(motor_bus.pin_a_high));
                if (motor_bus.pin_b_high !== want.pin_b)
                    note_error("pin_b_high", int'(want.pin_b), int'(motor_bus.pin_b_high));
                if (motor_bus.mode !== want.mode)
                    note_error("mode", int'(want.mode), int'(motor_bus.mode));
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items pending", cycle_count,
                     pending_cmds.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Sensor and configuration side: reset, directed sweep, then one random
    // course per register setting
    initial
    begin
        int p;
        steer_reset();
        rst_n                    <= 1'b0;
        sensor_bus.valid         <= 1'b0;
        sensor_bus.left_sensor   <= 1'b0;
        sensor_bus.centre_sensor <= 1'b0;
        sensor_bus.right_sensor  <= 1'b0;
        cfg_bus.valid            <= 1'b0;
        cfg_bus.index            <= '0;
        cfg_bus.data             <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed sweep under the reset gains: every sensor pattern, every
        // mode, each wrap-around out of hard turn, and each hard-turn direction rule
        for (int k = 0; k < PROBE_ROWS; k++)
            send_item(PROBE_TABLE[k].left_on, PROBE_TABLE[k].centre_on,
                      PROBE_TABLE[k].right_on, PROBE_TABLE[k].typed, PROBE_TABLE[k].cmd);
        // Hold the sender until the pipeline is empty
        wait_drained();

        for (p = 0; p < SETTING_RUNS; p++)
        begin
            case (p)
                // in-range random gains
                0: load_settings($urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 1023), $urandom_range(0, 256),
                                 $urandom_range(0, 15), $urandom_range(0, 255),
                                 $urandom_range(20, 255), $urandom_range(0, 255));
                // everything at its top
                1: load_settings(255, 255, 1023, 256, 15, 255, 255, 255);
                // everything at its bottom: no correction, stop on first lost tick
                2: load_settings(0, 0, 0, 0, 0, 0, 20, 0);
                // smoothing past full weight, floor under the side margin
                3: load_settings($urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 1023), 1023,
                                 $urandom_range(0, 15), $urandom_range(0, 255),
                                 $urandom_range(0, 19), $urandom_range(0, 60));
                // raw 10-bit data: upper bits must be masked off
                default: load_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                                       $urandom_range(0, 1023), $urandom_range(0, 1023),
                                       $urandom_range(0, 1023), $urandom_range(0, 1023),
                                       $urandom_range(0, 1023), $urandom_range(0, 1023));
            endcase
            // With the top timeout, stay lost long enough to saturate the tick count
            if (p == 1)
            begin
                send_sensors(1'b1, 1'b0, 1'b0);
                repeat (LOST_BURST)
                    send_sensors(1'b0, 1'b0, 1'b0);
            end
            drive_course(PHASE_ITEMS);
            wait_drained();
        end

        // Catch any stray motor item after the last expected one
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_cmds.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
rtl/lfps_pkg.sv
rtl/lfps_in_if.sv
rtl/lfps_out_if.sv
rtl/lfps_cfg_if.sv
rtl/line_follower_pid_steering_core.sv
test/line_follower_pid_steering_core_tb.sv
